// ===== hdl/sat_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the sorted table.
package sat_pkg;

  localparam int DEPTH         = 256;
  localparam int DATA_BITS     = 32;
  localparam int ADDR_BITS     = $clog2(DEPTH);
  localparam int CNT_BITS      = $clog2(DEPTH + 1);
  localparam int CAP_BITS      = 9;
  localparam int POS_BITS      = 8;
  localparam int KIND_BITS     = 2;
  localparam int STATUS_BITS   = 2;
  localparam int IN_DATA_BITS  = 40;
  localparam int OUT_DATA_BITS = 48;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - DATA_BITS - STATUS_BITS - CNT_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(256);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RA_POS,
    RA_POS_P1,
    RA_CNT_M1,
    RA_K_M2,
    RA_K_P2
  } raddr_sel_e;

  typedef struct packed {
    logic       take;
    logic       k_ld_cnt;
    logic       k_ld_pos;
    logic       k_dec;
    logic       k_inc;
    raddr_sel_e raddr_sel;
    logic       we;
    logic       wsel_val;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_status;
    status_e    status;
    logic       cap_rd;
    logic       out_ld;
  } sat_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  pos_ok;
    logic  cnt_zero;
    logic  last_pos;
    logic  ge;
    logic  k_one;
    logic  del_end;
    logic  out_free;
  } sat_sts_t;

endpackage

// ===== hdl/sat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sat_datapath.sv =====
// Datapath: operand and count registers, entry memory, compare and result register.
module sat_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sat_pkg::CAP_BITS-1:0]          cfg_wdata_i,
  input  logic [sat_pkg::IN_DATA_BITS-1:0]      s_tdata_i,
  input  logic [sat_pkg::KIND_BITS-1:0]         s_tuser_i,
  input  sat_pkg::sat_cmd_t                     cmd_i,
  output sat_pkg::sat_sts_t                     sts_o,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [sat_pkg::OUT_DATA_BITS-1:0]     m_tdata_o
);

  sat_pkg::kind_e                      kind_q;
  logic [sat_pkg::DATA_BITS-1:0]       val_q;
  logic [sat_pkg::POS_BITS-1:0]        pos_q;
  logic [sat_pkg::CNT_BITS-1:0]        cnt_q, cnt_d;
  logic [sat_pkg::CAP_BITS-1:0]        cap_q;
  logic [sat_pkg::CNT_BITS-1:0]        k_q, k_d;
  sat_pkg::status_e                    res_st_q;
  logic [sat_pkg::DATA_BITS-1:0]       res_rd_q;
  logic                                m_valid_q;
  logic [sat_pkg::OUT_DATA_BITS-1:0]   m_data_q;

  logic [sat_pkg::CNT_BITS-1:0]        raddr;
  logic [sat_pkg::CNT_BITS-1:0]        pos_ext;
  logic [sat_pkg::CAP_BITS-1:0]        limit;
  logic [sat_pkg::DATA_BITS-1:0]       rdata;
  logic [sat_pkg::DATA_BITS-1:0]       wdata;

  assign pos_ext = sat_pkg::CNT_BITS'(pos_q);
  assign limit   = (cap_q > sat_pkg::CAP_BITS'(sat_pkg::DEPTH))
                   ? sat_pkg::CAP_BITS'(sat_pkg::DEPTH) : cap_q;

  always_comb begin
    priority if (cmd_i.k_ld_cnt) begin
      k_d = cnt_q;
    end else if (cmd_i.k_ld_pos) begin
      k_d = pos_ext;
    end else if (cmd_i.k_dec) begin
      k_d = k_q - 1'b1;
    end else if (cmd_i.k_inc) begin
      k_d = k_q + 1'b1;
    end else begin
      k_d = k_q;
    end
  end

  always_comb begin
    priority if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_comb begin
    unique case (cmd_i.raddr_sel)
      sat_pkg::RA_POS:    raddr = pos_ext;
      sat_pkg::RA_POS_P1: raddr = pos_ext + 1'b1;
      sat_pkg::RA_CNT_M1: raddr = cnt_q - 1'b1;
      sat_pkg::RA_K_M2:   raddr = k_q - 2'd2;
      sat_pkg::RA_K_P2:   raddr = k_q + 2'd2;
      default:            raddr = pos_ext;
    endcase
  end

  assign wdata = cmd_i.wsel_val ? val_q : rdata;

  sat_ram #(
    .WIDTH (sat_pkg::DATA_BITS),
    .DEPTH (sat_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (k_q[sat_pkg::ADDR_BITS-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[sat_pkg::ADDR_BITS-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cap_q     <= sat_pkg::CAP_RESET;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
      k_q   <= k_d;
      if (cmd_i.out_ld) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q <= sat_pkg::kind_e'(s_tuser_i);
      val_q  <= s_tdata_i[sat_pkg::DATA_BITS-1:0];
      pos_q  <= s_tdata_i[sat_pkg::DATA_BITS +: sat_pkg::POS_BITS];
    end
    if (cmd_i.set_status) begin
      res_st_q <= cmd_i.status;
      res_rd_q <= '0;
    end else if (cmd_i.cap_rd) begin
      res_rd_q <= rdata;
    end
    if (cmd_i.out_ld) begin
      m_data_q <= {{sat_pkg::OUT_PAD_BITS{1'b0}}, cnt_q, res_st_q, res_rd_q};
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.full     = cnt_q >= limit;
  assign sts_o.pos_ok   = pos_ext < cnt_q;
  assign sts_o.cnt_zero = cnt_q == '0;
  assign sts_o.last_pos = (pos_ext + 1'b1) == cnt_q;
  assign sts_o.ge       = rdata >= val_q;
  assign sts_o.k_one    = k_q == sat_pkg::CNT_BITS'(1);
  assign sts_o.del_end  = (k_q + 2'd2) == cnt_q;
  assign sts_o.out_free = !m_valid_q || m_tready_i;

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

endmodule

// ===== hdl/sat_ctrl.sv =====
// Controller: sequences insert, read and delete over the datapath.
module sat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  sat_pkg::sat_sts_t sts_i,
  output sat_pkg::sat_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_RD_CAP,
    S_INS_LOOP,
    S_INS_PUT,
    S_DEL_LOOP,
    S_OUT
  } state_e;

  state_e            state_q, state_d;
  sat_pkg::sat_cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd.take = 1'b1;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        cmd.set_status = 1'b1;
        cmd.status     = sat_pkg::STS_OK;
        unique case (sts_i.kind)
          sat_pkg::KIND_INSERT: begin
            if (sts_i.full) begin
              cmd.status = sat_pkg::STS_FULL;
              state_d    = S_OUT;
            end else begin
              cmd.k_ld_cnt  = 1'b1;
              cmd.raddr_sel = sat_pkg::RA_CNT_M1;
              state_d       = sts_i.cnt_zero ? S_INS_PUT : S_INS_LOOP;
            end
          end
          sat_pkg::KIND_READ: begin
            if (!sts_i.pos_ok) begin
              cmd.status = sat_pkg::STS_RANGE;
              state_d    = S_OUT;
            end else begin
              cmd.raddr_sel = sat_pkg::RA_POS;
              state_d       = S_RD_CAP;
            end
          end
          sat_pkg::KIND_DELETE: begin
            if (!sts_i.pos_ok) begin
              cmd.status = sat_pkg::STS_RANGE;
              state_d    = S_OUT;
            end else if (sts_i.last_pos) begin
              cmd.cnt_dec = 1'b1;
              state_d     = S_OUT;
            end else begin
              cmd.k_ld_pos  = 1'b1;
              cmd.raddr_sel = sat_pkg::RA_POS_P1;
              state_d       = S_DEL_LOOP;
            end
          end
          default: begin
            state_d = S_OUT;
          end
        endcase
      end
      S_RD_CAP: begin
        cmd.cap_rd = 1'b1;
        state_d    = S_OUT;
      end
      S_INS_LOOP: begin
        // read data is the entry just below the write slot
        cmd.we = 1'b1;
        if (sts_i.ge) begin
          cmd.k_dec     = 1'b1;
          cmd.raddr_sel = sat_pkg::RA_K_M2;
          if (sts_i.k_one) begin
            state_d = S_INS_PUT;
          end
        end else begin
          cmd.wsel_val = 1'b1;
          cmd.cnt_inc  = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_INS_PUT: begin
        cmd.we       = 1'b1;
        cmd.wsel_val = 1'b1;
        cmd.cnt_inc  = 1'b1;
        state_d      = S_OUT;
      end
      S_DEL_LOOP: begin
        cmd.we        = 1'b1;
        cmd.k_inc     = 1'b1;
        cmd.raddr_sel = sat_pkg::RA_K_P2;
        if (sts_i.del_end) begin
          cmd.cnt_dec = 1'b1;
          state_d     = S_OUT;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd.out_ld = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = state_q == S_IDLE;
  assign cmd_o      = cmd;

endmodule

// ===== hdl/sorted_array_table_core.sv =====
// Top level of the sorted table: ascending 32-bit entries with insert, read and delete.
// One word at a time; the result becomes valid in the same cycle in which the next word can be accepted.
// Insert and delete shift the entries above the slot or position, one entry moved per cycle
// through the single-port-pair RAM; an output stall holds the block in its output state.
// Reset clears the count and sets capacity to 256; the entry memory is not cleared.
module sorted_array_table_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sat_pkg::CAP_BITS-1:0]          cfg_wdata_i,      // capacity
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [sat_pkg::IN_DATA_BITS-1:0]      s_axis_tdata_i,   // value[31:0], position[39:32]
  input  logic [sat_pkg::KIND_BITS-1:0]         s_axis_tuser_i,   // kind[1:0]
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [sat_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata_o    // read_value[31:0],
                                                                  // status[33:32],
                                                                  // entry_count[42:34]
);

  sat_pkg::sat_cmd_t cmd;
  sat_pkg::sat_sts_t sts;

  sat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sat_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

// ===== hdl/sat_chk.sv =====
// Port-level checks for the sorted table, bound to the top level.
module sat_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_tvalid_i,
  input logic                              s_tready_i,
  input logic                              m_tvalid_i,
  input logic                              m_tready_i,
  input logic [sat_pkg::OUT_DATA_BITS-1:0] m_tdata_i
);

  logic [sat_pkg::DATA_BITS-1:0]   rd_value;
  logic [sat_pkg::STATUS_BITS-1:0] status;
  logic [sat_pkg::CNT_BITS-1:0]    count;

  assign rd_value = m_tdata_i[sat_pkg::DATA_BITS-1:0];
  assign status   = m_tdata_i[sat_pkg::DATA_BITS +: sat_pkg::STATUS_BITS];
  assign count    = m_tdata_i[sat_pkg::DATA_BITS + sat_pkg::STATUS_BITS +: sat_pkg::CNT_BITS];

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input accepted while previous word still in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> count <= sat_pkg::CNT_BITS'(sat_pkg::DEPTH))
    else $error("entry count beyond table depth");

  a_error_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && status != sat_pkg::STS_OK |-> rd_value == '0)
    else $error("read value nonzero on refused operation");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("result word changed while stalled");

endmodule

bind sorted_array_table_core sat_chk u_sat_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

// ===== test/sorted_array_table_core_test.sv =====
// Self-checking testbench for sorted_array_table_core: insert, read, delete and capacity limits.
module sorted_array_table_core_test;

  localparam logic [sat_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [sat_pkg::DATA_BITS-1:0] read_value;
    sat_pkg::status_e              status;
    logic [sat_pkg::CNT_BITS-1:0]  entry_count;
  } table_reply_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic [sat_pkg::CAP_BITS-1:0]      cfg_wdata_i = '0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic [sat_pkg::IN_DATA_BITS-1:0]  s_axis_tdata_i = '0;
  logic [sat_pkg::KIND_BITS-1:0]     s_axis_tuser_i = '0;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic [sat_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o;

  logic [sat_pkg::DATA_BITS-1:0] tbl_entry [sat_pkg::DEPTH];
  int                            tbl_count = 0;
  logic [sat_pkg::CAP_BITS-1:0]  tbl_cap = sat_pkg::CAP_RESET;
  table_reply_t                  due_replies [$];

  bit pace_on = 1'b1;
  int rx_hold = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_range = 0;
  int peak_count = 0;

  sorted_array_table_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  function automatic table_reply_t apply_table_op(logic [sat_pkg::KIND_BITS-1:0] kind,
                                                  logic [sat_pkg::DATA_BITS-1:0] value,
                                                  logic [sat_pkg::POS_BITS-1:0] pos);
    table_reply_t reply;
    int lim;
    int slot;
    int k;
    reply.read_value = '0;
    reply.status = sat_pkg::STS_OK;
    lim = (int'(tbl_cap) < sat_pkg::DEPTH) ? int'(tbl_cap) : sat_pkg::DEPTH;
    case (kind)
      sat_pkg::KIND_INSERT: begin
        if (tbl_count >= lim) begin
          reply.status = sat_pkg::STS_FULL;
          n_full++;
        end else begin
          slot = 0;
          while (slot < tbl_count && tbl_entry[sat_pkg::ADDR_BITS'(slot)] < value) slot++;
          for (k = tbl_count; k > slot; k--)
            tbl_entry[sat_pkg::ADDR_BITS'(k)] = tbl_entry[sat_pkg::ADDR_BITS'(k - 1)];
          tbl_entry[sat_pkg::ADDR_BITS'(slot)] = value;
          tbl_count++;
        end
      end
      sat_pkg::KIND_READ: begin
        if (int'(pos) < tbl_count) begin
          reply.read_value = tbl_entry[pos];
        end else begin
          reply.status = sat_pkg::STS_RANGE;
          n_range++;
        end
      end
      sat_pkg::KIND_DELETE: begin
        if (int'(pos) < tbl_count) begin
          for (k = int'(pos); k + 1 < tbl_count; k++)
            tbl_entry[sat_pkg::ADDR_BITS'(k)] = tbl_entry[sat_pkg::ADDR_BITS'(k + 1)];
          tbl_count--;
        end else begin
          reply.status = sat_pkg::STS_RANGE;
          n_range++;
        end
      end
      default: ;
    endcase
    if (tbl_count > peak_count) peak_count = tbl_count;
    reply.entry_count = sat_pkg::CNT_BITS'(tbl_count);
    return reply;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [sat_pkg::DATA_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1: return sat_pkg::DATA_BITS'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      3: return (tbl_count > 0)
                ? tbl_entry[sat_pkg::ADDR_BITS'($urandom_range(0, tbl_count - 1))]
                : $urandom();
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [sat_pkg::POS_BITS-1:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (tbl_count > 0 && r < 7)
      return sat_pkg::POS_BITS'($urandom_range(0, tbl_count - 1));
    if (r == 7 && tbl_count < sat_pkg::DEPTH) return sat_pkg::POS_BITS'(tbl_count);
    return sat_pkg::POS_BITS'($urandom_range(0, 255));
  endfunction

  task automatic flag_mismatch(string what, logic [sat_pkg::OUT_DATA_BITS-1:0] got,
                               logic [sat_pkg::OUT_DATA_BITS-1:0] want);
    n_errors++;
    if (n_errors <= 50)
      $display("MISMATCH @%0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : reply_check
    table_reply_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (due_replies.size() == 0) begin
        flag_mismatch("word with none pending", m_axis_tdata_o, '0);
      end else begin
        want = due_replies.pop_front();
        n_checked++;
        if (m_axis_tdata_o[31:0] !== want.read_value)
          flag_mismatch("read_value", sat_pkg::OUT_DATA_BITS'(m_axis_tdata_o[31:0]),
                        sat_pkg::OUT_DATA_BITS'(want.read_value));
        if (m_axis_tdata_o[33:32] !== want.status)
          flag_mismatch("status", sat_pkg::OUT_DATA_BITS'(m_axis_tdata_o[33:32]),
                        sat_pkg::OUT_DATA_BITS'(want.status));
        if (m_axis_tdata_o[42:34] !== want.entry_count)
          flag_mismatch("entry_count", sat_pkg::OUT_DATA_BITS'(m_axis_tdata_o[42:34]),
                        sat_pkg::OUT_DATA_BITS'(want.entry_count));
      end
    end
  end

  initial begin : reply_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready_i <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        stall--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (pace_on && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  task automatic send_word(logic [sat_pkg::KIND_BITS-1:0] kind,
                           logic [sat_pkg::DATA_BITS-1:0] value,
                           logic [sat_pkg::POS_BITS-1:0] pos);
    int gap;
    gap = pace_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pos, value};
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    due_replies.push_back(apply_table_op(kind, value, pos));
    n_sent++;
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    s_axis_tvalid_i <= 1'b0;
    while (due_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (due_replies.size() != 0) begin
      flag_mismatch("words never returned", sat_pkg::OUT_DATA_BITS'(due_replies.size()), '0);
      due_replies.delete();
    end
  endtask

  task automatic set_capacity(logic [sat_pkg::CAP_BITS-1:0] cap);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tbl_cap = cap;
  endtask

  task automatic run_random_ops(int n, int w_ins, int w_rd, int w_del);
    int i;
    int r;
    logic [sat_pkg::KIND_BITS-1:0] kind;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) kind = sat_pkg::KIND_INSERT;
      else if (r < w_ins + w_rd) kind = sat_pkg::KIND_READ;
      else if (r < w_ins + w_rd + w_del) kind = sat_pkg::KIND_DELETE;
      else kind = KIND_UNUSED;
      if (kind == sat_pkg::KIND_INSERT)
        send_word(kind, pick_value(), sat_pkg::POS_BITS'($urandom_range(0, 255)));
      else
        send_word(kind, $urandom(), pick_position());
    end
  endtask

  task automatic test_directed_ops();
    int p;
    send_word(sat_pkg::KIND_READ, 32'h0, 8'd0);
    send_word(sat_pkg::KIND_DELETE, 32'h0, 8'd0);
    send_word(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    send_word(sat_pkg::KIND_INSERT, 32'h8000_0000, 8'hFF);
    send_word(sat_pkg::KIND_INSERT, 32'hFFFF_FFFF, 8'h00);
    send_word(sat_pkg::KIND_INSERT, 32'h0000_0000, 8'h00);
    send_word(sat_pkg::KIND_INSERT, 32'h7FFF_FFFF, 8'h55);
    send_word(sat_pkg::KIND_INSERT, 32'h7FFF_FFFF, 8'hAA);
    for (p = 0; p < 5; p++) send_word(sat_pkg::KIND_READ, 32'hFFFF_FFFF, sat_pkg::POS_BITS'(p));
    send_word(sat_pkg::KIND_READ, 32'h0, 8'hFF);
    send_word(sat_pkg::KIND_DELETE, 32'h0, 8'd5);
    send_word(sat_pkg::KIND_DELETE, 32'hFFFF_FFFF, 8'd4);
    send_word(sat_pkg::KIND_DELETE, 32'h0, 8'd0);
  endtask

  task automatic test_capacity_limits();
    set_capacity(9'd0);
    send_word(sat_pkg::KIND_INSERT, 32'h1, 8'd0);
    send_word(sat_pkg::KIND_READ, 32'h0, 8'd2);
    // capacity now below the held count
    set_capacity(9'd2);
    send_word(sat_pkg::KIND_INSERT, 32'h2, 8'd0);
    send_word(sat_pkg::KIND_DELETE, 32'h0, 8'd1);
    send_word(sat_pkg::KIND_INSERT, 32'h3, 8'd0);
    send_word(sat_pkg::KIND_DELETE, 32'h0, 8'd0);
    send_word(sat_pkg::KIND_INSERT, 32'h1234_5678, 8'd0);
    set_capacity(9'd1);
    send_word(sat_pkg::KIND_INSERT, 32'h4, 8'd0);
  endtask

  task automatic test_fill_to_depth();
    set_capacity(9'd511);
    run_random_ops(300, 92, 6, 1);
  endtask

  task automatic test_shrink_and_drain();
    set_capacity(9'd40);
    run_random_ops(170, 8, 30, 60);
    set_capacity(9'd1);
    run_random_ops(250, 8, 15, 75);
  endtask

  task automatic test_backpressure();
    set_capacity(9'd256);
    rx_hold = 800;
    run_random_ops(15, 50, 30, 18);
    wait_drained();
  endtask

  task automatic test_no_idle();
    set_capacity(9'd17);
    pace_on = 1'b0;
    run_random_ops(100, 45, 30, 23);
    wait_drained();
    pace_on = 1'b1;
  endtask

  task automatic test_mixed_traffic();
    set_capacity(9'd256);
    run_random_ops(100, 45, 30, 23);
    set_capacity(9'd0);
    run_random_ops(40, 40, 30, 28);
  endtask

  initial begin : run_tests
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed_ops();
    test_capacity_limits();
    test_fill_to_depth();
    test_shrink_and_drain();
    test_backpressure();
    test_no_idle();
    test_mixed_traffic();
    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("Ran %0d operations over capacities 0, 1, 2, 17, 40, 256 and 511; %0d words checked",
             n_sent, n_checked);
    $display("Refused as full: %0d, index out of range: %0d, peak entry count: %0d",
             n_full, n_range, peak_count);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
